### design/nms_pkg.sv
`timescale 1ns / 1ps
package nms_pkg;

	localparam int MAX_BOXES_DEF  = 64;
	localparam int COORD_BITS_DEF = 12;
	localparam int SCORE_BITS_DEF = 16;

	localparam int THR_BITS  = 16;
	localparam int MODE_BITS = 2;
	localparam int REG_BITS  = 16;
	localparam int IDX_BITS  = 2;

	localparam logic [THR_BITS-1:0] THR_RESET = 16'd45875;

	localparam logic [IDX_BITS-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [IDX_BITS-1:0] REG_MODE      = 2'd1;

	localparam logic [MODE_BITS-1:0] MODE_IOU  = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_IOS  = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_NONE = 2'd2;

	// depth of the overlap pipeline that closes the ring of cells
	localparam int PIPE_DEPTH = 5;

	typedef struct packed {
		logic clear;
		logic load;
		logic rot;
	} cell_ctl_t;

endpackage

### design/nms_cell.sv
`timescale 1ns / 1ps
module nms_cell #(
	parameter int CW = 12,
	parameter int SW = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  nms_pkg::cell_ctl_t ctl,
	input  logic [CW-1:0]      new_left,
	input  logic [CW-1:0]      new_top,
	input  logic [CW-1:0]      new_right,
	input  logic [CW-1:0]      new_bottom,
	input  logic [SW-1:0]      new_score,
	input  logic               prev_ins,
	input  logic               prev_valid,
	input  logic [CW-1:0]      prev_left,
	input  logic [CW-1:0]      prev_top,
	input  logic [CW-1:0]      prev_right,
	input  logic [CW-1:0]      prev_bottom,
	input  logic [SW-1:0]      prev_score,
	input  logic               next_valid,
	input  logic               next_supp,
	input  logic [CW-1:0]      next_left,
	input  logic [CW-1:0]      next_top,
	input  logic [CW-1:0]      next_right,
	input  logic [CW-1:0]      next_bottom,
	input  logic [SW-1:0]      next_score,
	output logic               ins,
	output logic               valid,
	output logic               supp,
	output logic [CW-1:0]      left,
	output logic [CW-1:0]      top,
	output logic [CW-1:0]      right,
	output logic [CW-1:0]      bottom,
	output logic [SW-1:0]      score
);
	import nms_pkg::*;

	logic          valid_q;
	logic          supp_q;
	logic [CW-1:0] left_q;
	logic [CW-1:0] top_q;
	logic [CW-1:0] right_q;
	logic [CW-1:0] bottom_q;
	logic [SW-1:0] score_q;

	// new box goes in front of this cell; equal scores stay ahead
	assign ins = !valid_q || (score_q < new_score);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			supp_q  <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
			supp_q  <= 1'b0;
		end else if (ctl.load && ins) begin
			valid_q <= prev_ins ? prev_valid : 1'b1;
			supp_q  <= 1'b0;
		end else if (ctl.rot) begin
			valid_q <= next_valid;
			supp_q  <= next_supp;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load && ins) begin
			if (prev_ins) begin
				left_q   <= prev_left;
				top_q    <= prev_top;
				right_q  <= prev_right;
				bottom_q <= prev_bottom;
				score_q  <= prev_score;
			end else begin
				left_q   <= new_left;
				top_q    <= new_top;
				right_q  <= new_right;
				bottom_q <= new_bottom;
				score_q  <= new_score;
			end
		end else if (ctl.rot) begin
			left_q   <= next_left;
			top_q    <= next_top;
			right_q  <= next_right;
			bottom_q <= next_bottom;
			score_q  <= next_score;
		end
	end

	assign valid  = valid_q;
	assign supp   = supp_q;
	assign left   = left_q;
	assign top    = top_q;
	assign right  = right_q;
	assign bottom = bottom_q;
	assign score  = score_q;

endmodule

### design/nms_ovl.sv
`timescale 1ns / 1ps
module nms_ovl #(
	parameter int CW = 12,
	parameter int SW = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic [nms_pkg::THR_BITS-1:0]      threshold,
	input  logic [nms_pkg::MODE_BITS-1:0]     mode,
	input  logic [CW-1:0]                     k_left,
	input  logic [CW-1:0]                     k_top,
	input  logic [CW-1:0]                     k_right,
	input  logic [CW-1:0]                     k_bottom,
	input  logic [2*CW+1:0]                   k_area,
	input  logic                              in_valid,
	input  logic                              in_supp,
	input  logic [CW-1:0]                     in_left,
	input  logic [CW-1:0]                     in_top,
	input  logic [CW-1:0]                     in_right,
	input  logic [CW-1:0]                     in_bottom,
	input  logic [SW-1:0]                     in_score,
	output logic                              out_valid,
	output logic                              out_supp,
	output logic [CW-1:0]                     out_left,
	output logic [CW-1:0]                     out_top,
	output logic [CW-1:0]                     out_right,
	output logic [CW-1:0]                     out_bottom,
	output logic [SW-1:0]                     out_score
);
	import nms_pkg::*;

	localparam int IW = 2*CW+2;
	localparam int AW = 2*CW+3;
	localparam int PW = THR_BITS+AW;
	localparam int BW = 4*CW+SW;

	logic [PIPE_DEPTH-1:0] v_q;
	logic [PIPE_DEPTH-1:0] sp_q;
	logic [BW-1:0]         box_q [PIPE_DEPTH];

	logic [CW-1:0] ql, qr, qt, qb, kl, kr, kt, kb;
	logic signed [CW+1:0] iw, ih;
	logic [CW:0]   w_s2, h_s2, wq_s2, hq_s2;
	logic          pos_s2, pos_s3, pos_s4, pos_s5;
	logic [IW-1:0] inter_s3, aq_s3, inter_s4, inter_s5;
	logic [AW-1:0] den, den_s4;
	logic [PW-1:0] prod_s5;
	logic          hit;

	function automatic logic [CW-1:0] in_lft();
		return box_q[0][CW-1:0];
	endfunction
	function automatic logic [CW-1:0] in_tp();
		return box_q[0][2*CW-1:CW];
	endfunction
	function automatic logic [CW-1:0] in_rgt();
		return box_q[0][3*CW-1:2*CW];
	endfunction
	function automatic logic [CW-1:0] in_bt();
		return box_q[0][4*CW-1:3*CW];
	endfunction

	always_comb begin
		ql = (in_lft() < in_rgt()) ? in_lft() : in_rgt();
		qr = (in_lft() < in_rgt()) ? in_rgt() : in_lft();
		qt = (in_tp() < in_bt()) ? in_tp() : in_bt();
		qb = (in_tp() < in_bt()) ? in_bt() : in_tp();
		kl = (k_left < k_right) ? k_left : k_right;
		kr = (k_left < k_right) ? k_right : k_left;
		kt = (k_top < k_bottom) ? k_top : k_bottom;
		kb = (k_top < k_bottom) ? k_bottom : k_top;
		iw = $signed({2'b00, ((qr < kr) ? qr : kr)}) - $signed({2'b00, ((ql > kl) ? ql : kl)})
			+ $signed((CW+2)'(1));
		ih = $signed({2'b00, ((qb < kb) ? qb : kb)}) - $signed({2'b00, ((qt > kt) ? qt : kt)})
			+ $signed((CW+2)'(1));
	end

	always_comb begin
		if (mode == MODE_IOU) begin
			den = AW'(k_area) + AW'(aq_s3) - AW'(inter_s3);
		end else begin
			den = AW'((k_area < aq_s3) ? k_area : aq_s3);
		end
	end

	assign hit = pos_s5 && (mode == MODE_IOU || mode == MODE_IOS)
		&& ({PW'(inter_s5), THR_BITS'(0)} > {THR_BITS'(0), prod_s5});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q  <= '0;
			sp_q <= '0;
		end else if (en) begin
			v_q  <= {v_q[PIPE_DEPTH-2:0], in_valid};
			sp_q <= {sp_q[PIPE_DEPTH-2:0], in_supp};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			box_q[0] <= {in_score, in_bottom, in_right, in_top, in_left};
			for (int i = 1; i < PIPE_DEPTH; i++) begin
				box_q[i] <= box_q[i-1];
			end
			// stage 2: extents
			pos_s2 <= (iw > 0) && (ih > 0);
			w_s2   <= iw[CW:0];
			h_s2   <= ih[CW:0];
			wq_s2  <= (CW+1)'(qr) - (CW+1)'(ql) + (CW+1)'(1);
			hq_s2  <= (CW+1)'(qb) - (CW+1)'(qt) + (CW+1)'(1);
			// stage 3: areas
			inter_s3 <= IW'(w_s2) * IW'(h_s2);
			aq_s3    <= IW'(wq_s2) * IW'(hq_s2);
			pos_s3   <= pos_s2;
			// stage 4: denominator
			den_s4   <= den;
			inter_s4 <= inter_s3;
			pos_s4   <= pos_s3;
			// stage 5: threshold product
			prod_s5  <= PW'(threshold) * PW'(den_s4);
			inter_s5 <= inter_s4;
			pos_s5   <= pos_s4;
		end
	end

	assign out_valid  = v_q[PIPE_DEPTH-1];
	assign out_supp   = sp_q[PIPE_DEPTH-1] | hit;
	assign out_left   = box_q[PIPE_DEPTH-1][CW-1:0];
	assign out_top    = box_q[PIPE_DEPTH-1][2*CW-1:CW];
	assign out_right  = box_q[PIPE_DEPTH-1][3*CW-1:2*CW];
	assign out_bottom = box_q[PIPE_DEPTH-1][4*CW-1:3*CW];
	assign out_score  = box_q[PIPE_DEPTH-1][BW-1:4*CW];

endmodule

### design/non_maximum_suppression.sv
`timescale 1ns / 1ps
// Greedy non-maximum suppression over one set of boxes.
// Input beats on s_* carry one box each; s_tlast marks the last box of the
// set. Boxes are insertion-sorted by descending score into a row of cells,
// one cycle per box. Boxes beyond MAX_BOXES are dropped and flagged on
// m_tuser for every kept box of that set.
// After the last box, s_tready drops and the cells rotate as a ring through
// a PIPE_DEPTH-stage overlap pipeline. Each pass over the ring keeps at
// most one box, and the set ends after a pass that keeps none.
// Kept boxes leave on m_* in score order, m_tlast on the last one; one beat
// is held back so the last can be marked. A stalled receiver stops the ring
// when a new kept box finds both output slots full.
// Config writes (wr_en, wr_index, wr_data) must only be made between sets.
// Reset empties the cells, clears the output and restores the registers.
module non_maximum_suppression
	import nms_pkg::*;
#(
	parameter int MAX_BOXES  = MAX_BOXES_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int SCORE_BITS = SCORE_BITS_DEF,
	localparam int DW = ((4*COORD_BITS+SCORE_BITS+7)/8)*8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [nms_pkg::IDX_BITS-1:0]  wr_index,
	input  logic [nms_pkg::REG_BITS-1:0]  wr_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// box_left, box_top, box_right, box_bottom, box_score
	input  logic [DW-1:0]                 s_tdata,
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// kept_left, kept_top, kept_right, kept_bottom, kept_score
	output logic [DW-1:0]                 m_tdata,
	output logic                          m_tlast,
	// overflowed
	output logic                          m_tuser
);
	localparam int CW     = COORD_BITS;
	localparam int SW     = SCORE_BITS;
	localparam int L      = MAX_BOXES + PIPE_DEPTH;
	localparam int CNT_W  = $clog2(MAX_BOXES+1);
	localparam int STEP_W = $clog2(L);

	localparam logic [1:0] ST_LOAD  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	logic [1:0]            state_q;
	logic [CNT_W-1:0]      count_q;
	logic                  drop_q;
	logic [STEP_W-1:0]     step_q;
	logic                  kset_q;
	logic [THR_BITS-1:0]   thr_q;
	logic [MODE_BITS-1:0]  mode_q;

	logic [CW-1:0] n_left, n_top, n_right, n_bottom;
	logic [SW-1:0] n_score;

	logic [CW-1:0] c_left [MAX_BOXES];
	logic [CW-1:0] c_top [MAX_BOXES];
	logic [CW-1:0] c_right [MAX_BOXES];
	logic [CW-1:0] c_bottom [MAX_BOXES];
	logic [SW-1:0] c_score [MAX_BOXES];
	logic [MAX_BOXES-1:0] c_valid, c_supp, c_ins;

	logic          p_valid, p_supp;
	logic [CW-1:0] p_left, p_top, p_right, p_bottom;
	logic [SW-1:0] p_score;

	logic [CW-1:0] k_left_q, k_top_q, k_right_q, k_bottom_q;
	logic [2*CW+1:0] k_area_q;
	logic [CW:0]   k_w, k_h;

	logic          hold_valid_q, hold_drop_q;
	logic [CW-1:0] hold_left_q, hold_top_q, hold_right_q, hold_bottom_q;
	logic [SW-1:0] hold_score_q;
	logic          o_valid_q, o_last_q, o_drop_q;
	logic [CW-1:0] o_left_q, o_top_q, o_right_q, o_bottom_q;
	logic [SW-1:0] o_score_q;

	logic      in_beat, full, keep, o_free, step_en, pass_end, flush_go;
	cell_ctl_t ctl;

	assign n_left   = s_tdata[CW-1:0];
	assign n_top    = s_tdata[2*CW-1:CW];
	assign n_right  = s_tdata[3*CW-1:2*CW];
	assign n_bottom = s_tdata[4*CW-1:3*CW];
	assign n_score  = s_tdata[4*CW+SW-1:4*CW];

	assign s_tready = (state_q == ST_LOAD);
	assign in_beat  = s_tvalid && s_tready;
	assign full     = (count_q == CNT_W'(MAX_BOXES));
	assign o_free   = !o_valid_q || m_tready;
	assign keep     = (state_q == ST_RUN) && !kset_q && c_valid[0] && !c_supp[0];
	assign step_en  = (state_q == ST_RUN) && !(keep && hold_valid_q && !o_free);
	assign pass_end = step_en && (step_q == STEP_W'(L-1));
	assign flush_go = (state_q == ST_FLUSH) && o_free;

	assign ctl.clear = flush_go;
	assign ctl.load  = in_beat && !full;
	assign ctl.rot   = step_en;

	for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
		if (i == 0 && MAX_BOXES == 1) begin : g_one
		end
		nms_cell #(.CW(CW), .SW(SW)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.new_left   (n_left),
			.new_top    (n_top),
			.new_right  (n_right),
			.new_bottom (n_bottom),
			.new_score  (n_score),
			.prev_ins   ((i == 0) ? 1'b0 : c_ins[(i == 0) ? 0 : i-1]),
			.prev_valid (c_valid[(i == 0) ? 0 : i-1]),
			.prev_left  (c_left[(i == 0) ? 0 : i-1]),
			.prev_top   (c_top[(i == 0) ? 0 : i-1]),
			.prev_right (c_right[(i == 0) ? 0 : i-1]),
			.prev_bottom(c_bottom[(i == 0) ? 0 : i-1]),
			.prev_score (c_score[(i == 0) ? 0 : i-1]),
			.next_valid ((i == MAX_BOXES-1) ? p_valid : c_valid[(i == MAX_BOXES-1) ? i : i+1]),
			.next_supp  ((i == MAX_BOXES-1) ? p_supp : c_supp[(i == MAX_BOXES-1) ? i : i+1]),
			.next_left  ((i == MAX_BOXES-1) ? p_left : c_left[(i == MAX_BOXES-1) ? i : i+1]),
			.next_top   ((i == MAX_BOXES-1) ? p_top : c_top[(i == MAX_BOXES-1) ? i : i+1]),
			.next_right ((i == MAX_BOXES-1) ? p_right : c_right[(i == MAX_BOXES-1) ? i : i+1]),
			.next_bottom((i == MAX_BOXES-1) ? p_bottom
				: c_bottom[(i == MAX_BOXES-1) ? i : i+1]),
			.next_score ((i == MAX_BOXES-1) ? p_score : c_score[(i == MAX_BOXES-1) ? i : i+1]),
			.ins        (c_ins[i]),
			.valid      (c_valid[i]),
			.supp       (c_supp[i]),
			.left       (c_left[i]),
			.top        (c_top[i]),
			.right      (c_right[i]),
			.bottom     (c_bottom[i]),
			.score      (c_score[i])
		);
	end

	nms_ovl #(.CW(CW), .SW(SW)) u_ovl (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (step_en),
		.threshold (thr_q),
		.mode      (mode_q),
		.k_left    (k_left_q),
		.k_top     (k_top_q),
		.k_right   (k_right_q),
		.k_bottom  (k_bottom_q),
		.k_area    (k_area_q),
		.in_valid  (c_valid[0]),
		.in_supp   (c_supp[0] | keep),
		.in_left   (c_left[0]),
		.in_top    (c_top[0]),
		.in_right  (c_right[0]),
		.in_bottom (c_bottom[0]),
		.in_score  (c_score[0]),
		.out_valid (p_valid),
		.out_supp  (p_supp),
		.out_left  (p_left),
		.out_top   (p_top),
		.out_right (p_right),
		.out_bottom(p_bottom),
		.out_score (p_score)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= THR_RESET;
			mode_q <= MODE_IOU;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_THRESHOLD: thr_q  <= wr_data[THR_BITS-1:0];
				REG_MODE:      mode_q <= wr_data[MODE_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			count_q      <= '0;
			drop_q       <= 1'b0;
			step_q       <= '0;
			kset_q       <= 1'b0;
			hold_valid_q <= 1'b0;
			o_valid_q    <= 1'b0;
		end else begin
			if ((step_en && keep && hold_valid_q) || flush_go) begin
				o_valid_q <= 1'b1;
			end else if (m_tready) begin
				o_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (in_beat) begin
						if (full) begin
							drop_q <= 1'b1;
						end else begin
							count_q <= count_q + CNT_W'(1);
						end
						if (s_tlast) begin
							state_q <= ST_RUN;
							step_q  <= '0;
							kset_q  <= 1'b0;
						end
					end
				end
				ST_RUN: begin
					if (step_en) begin
						if (keep) begin
							hold_valid_q <= 1'b1;
						end
						if (pass_end) begin
							step_q <= '0;
							kset_q <= 1'b0;
							if (!(kset_q || keep)) begin
								state_q <= ST_FLUSH;
							end
						end else begin
							step_q <= step_q + STEP_W'(1);
							if (keep) begin
								kset_q <= 1'b1;
							end
						end
					end
				end
				ST_FLUSH: begin
					if (flush_go) begin
						hold_valid_q <= 1'b0;
						count_q      <= '0;
						drop_q       <= 1'b0;
						state_q      <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	assign k_w = ((k_left_q < k_right_q) ? (CW+1)'(k_right_q) - (CW+1)'(k_left_q)
		: (CW+1)'(k_left_q) - (CW+1)'(k_right_q)) + (CW+1)'(1);
	assign k_h = ((k_top_q < k_bottom_q) ? (CW+1)'(k_bottom_q) - (CW+1)'(k_top_q)
		: (CW+1)'(k_top_q) - (CW+1)'(k_bottom_q)) + (CW+1)'(1);

	always_ff @(posedge clk) begin
		k_area_q <= (2*CW+2)'(k_w) * (2*CW+2)'(k_h);
		if (step_en && keep) begin
			k_left_q      <= c_left[0];
			k_top_q       <= c_top[0];
			k_right_q     <= c_right[0];
			k_bottom_q    <= c_bottom[0];
			hold_left_q   <= c_left[0];
			hold_top_q    <= c_top[0];
			hold_right_q  <= c_right[0];
			hold_bottom_q <= c_bottom[0];
			hold_score_q  <= c_score[0];
			hold_drop_q   <= drop_q;
		end
		if ((step_en && keep && hold_valid_q) || flush_go) begin
			o_left_q   <= hold_left_q;
			o_top_q    <= hold_top_q;
			o_right_q  <= hold_right_q;
			o_bottom_q <= hold_bottom_q;
			o_score_q  <= hold_score_q;
			o_drop_q   <= hold_drop_q;
			o_last_q   <= flush_go;
		end
	end

	assign m_tvalid = o_valid_q;
	assign m_tdata  = DW'({o_score_q, o_bottom_q, o_right_q, o_top_q, o_left_q});
	assign m_tlast  = o_last_q;
	assign m_tuser  = o_drop_q;

endmodule

### design/nms_check.sv
`timescale 1ns / 1ps
module nms_check (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic s_tlast,
	input logic m_tvalid,
	input logic m_tready,
	input logic m_tlast
);

	// a stalled output beat is never withdrawn
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output beat withdrawn under stall");

	// the last box of a set closes the input while suppression runs
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("input still open after last box");

	// loading stays open between boxes of one set
	a_load_open: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tlast |=> s_tready)
		else $error("input closed in the middle of a set");

	// reopening the input coincides with the set's final kept beat
	a_reopen_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(s_tready) |-> m_tvalid && m_tlast)
		else $error("input reopened without final kept beat");

endmodule

bind non_maximum_suppression nms_check u_nms_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tlast  (m_tlast)
);

### tb/non_maximum_suppression_tb.sv
`timescale 1ns / 1ps
module non_maximum_suppression_tb;
	import nms_pkg::*;

	localparam int NBOX = MAX_BOXES_DEF;
	localparam int CB = COORD_BITS_DEF;
	localparam int SB = SCORE_BITS_DEF;
	localparam int DW = ((4*CB+SB+7)/8)*8;
	localparam int SET_CYCLES = (NBOX + 1) * (NBOX + PIPE_DEPTH) + 10;
	localparam int WATCHDOG = 40 * SET_CYCLES;

	// left in the lowest bits, matching the beat layout
	typedef struct packed {
		logic [SB-1:0] score;
		logic [CB-1:0] bottom;
		logic [CB-1:0] right;
		logic [CB-1:0] top;
		logic [CB-1:0] left;
	} box_t;

	typedef struct {
		box_t box;
		logic last;
	} load_t;

	typedef struct {
		box_t box;
		logic last;
		logic ovf;
	} kept_t;

	logic clk = 0, arst_n = 0;
	logic wr_en = 0;
	logic [IDX_BITS-1:0] wr_index = '0;
	logic [REG_BITS-1:0] wr_data = '0;
	logic s_tvalid = 0, s_tlast = 0, m_tready = 0;
	logic [DW-1:0] s_tdata = '0;
	logic s_tready, m_tvalid, m_tlast, m_tuser;
	logic [DW-1:0] m_tdata;

	non_maximum_suppression uut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// predictor state
	box_t sorted_boxes[$];
	logic drop_seen;
	logic [THR_BITS-1:0] thr;
	logic [MODE_BITS-1:0] mode;

	load_t pending_loads[$];
	kept_t kept_expected[$];
	int send_idle_pct, recv_stall_pct;
	int errors, sets_done, kept_seen, loads_sent, idle_cnt;
	bit done_sending;

	function automatic box_t norm(box_t b);
		box_t n = b;
		if (b.right < b.left) begin
			n.left = b.right;
			n.right = b.left;
		end
		if (b.bottom < b.top) begin
			n.top = b.bottom;
			n.bottom = b.top;
		end
		return n;
	endfunction

	function automatic bit too_close(box_t p0, box_t q0);
		box_t p, q;
		longint w, h, inter, a1, a2, den;
		p = norm(p0);
		q = norm(q0);
		w = longint'(p.right < q.right ? p.right : q.right)
			- longint'(p.left > q.left ? p.left : q.left) + 1;
		h = longint'(p.bottom < q.bottom ? p.bottom : q.bottom)
			- longint'(p.top > q.top ? p.top : q.top) + 1;
		if (w <= 0 || h <= 0) return 0;
		inter = w * h;
		a1 = longint'(p.right - p.left + 1) * longint'(p.bottom - p.top + 1);
		a2 = longint'(q.right - q.left + 1) * longint'(q.bottom - q.top + 1);
		if (mode == MODE_IOU) den = a1 + a2 - inter;
		else if (mode == MODE_IOS) den = a1 < a2 ? a1 : a2;
		else return 0;
		return (inter << 16) > longint'(thr) * den;
	endfunction

	task automatic predict_load(load_t ld);
		int pos;
		bit gone[NBOX];
		int n;
		kept_t k;
		if (sorted_boxes.size() >= NBOX) drop_seen = 1;
		else begin
			pos = sorted_boxes.size();
			while (pos > 0 && sorted_boxes[pos-1].score < ld.box.score) pos--;
			sorted_boxes.insert(pos, ld.box);
		end
		if (!ld.last) return;
		n = sorted_boxes.size();
		for (int i = 0; i < n; i++) gone[i] = 0;
		for (int i = 0; i < n; i++) begin
			if (gone[i]) continue;
			gone[i] = 1;
			k.box = sorted_boxes[i];
			k.last = 0;
			k.ovf = drop_seen;
			kept_expected.insert(kept_expected.size(), k);
			for (int j = i + 1; j < n; j++)
				if (!gone[j] && too_close(sorted_boxes[i], sorted_boxes[j])) gone[j] = 1;
		end
		kept_expected[$].last = 1;
		sorted_boxes.delete();
		drop_seen = 0;
	endtask

	// driver
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			predict_load(pending_loads.pop_front());
			loads_sent++;
		end
		if ((!s_tvalid || s_tready) ) begin
			if (pending_loads.size() > (s_tvalid && s_tready ? 0 : 0) &&
				$urandom_range(99) >= send_idle_pct) begin
				s_tvalid <= 1;
				s_tdata <= DW'(pending_loads[0].box);
				s_tlast <= pending_loads[0].last;
			end else
				s_tvalid <= 0;
		end
		m_tready <= $urandom_range(99) >= recv_stall_pct;
	end

	// monitor
	always @(posedge clk) begin
		kept_t e;
		box_t got;
		if (m_tvalid && m_tready) begin
			got = box_t'(m_tdata[4*CB+SB-1:0]);
			kept_seen++;
			if (kept_expected.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected kept box %h", m_tdata);
			end else begin
				e = kept_expected.pop_front();
				if (got !== e.box || m_tlast !== e.last || m_tuser !== e.ovf) begin
					errors++;
					if (errors <= 10)
						$display("kept box mismatch: exp %h last %b ovf %b, got %h last %b ovf %b",
							e.box, e.last, e.ovf, m_tdata, m_tlast, m_tuser);
				end
				if (e.last) sets_done++;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cnt <= 0;
		else idle_cnt <= idle_cnt + 1;
		if (idle_cnt > WATCHDOG) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic box_t rand_box(int span);
		box_t b;
		int x, y;
		x = $urandom_range(4095 - span);
		y = $urandom_range(4095 - span);
		b.left = CB'(x);
		b.top = CB'(y);
		b.right = CB'(x + $urandom_range(span));
		b.bottom = CB'(y + $urandom_range(span));
		b.score = SB'($urandom);
		if ($urandom_range(9) == 0) b.score = SB'($urandom_range(3));
		return b;
	endfunction

	function automatic box_t mk(int l, int t, int r, int b, int s);
		box_t x;
		x.left = CB'(l);
		x.top = CB'(t);
		x.right = CB'(r);
		x.bottom = CB'(b);
		x.score = SB'(s);
		return x;
	endfunction

	task automatic queue_box(box_t b, logic last);
		load_t ld;
		ld.box = b;
		ld.last = last;
		pending_loads.insert(pending_loads.size(), ld);
	endtask

	task automatic drain();
		while (pending_loads.size() > 0 || s_tvalid || kept_expected.size() > 0)
			@(posedge clk);
		repeat (2 * (NBOX + PIPE_DEPTH) + 10) @(posedge clk);
	endtask

	task automatic write_reg(logic [IDX_BITS-1:0] idx, logic [REG_BITS-1:0] val);
		wr_en <= 1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 0;
		if (idx == REG_THRESHOLD) thr = val;
		else if (idx == REG_MODE) mode = val[MODE_BITS-1:0];
		@(posedge clk);
	endtask

	task automatic random_sets(int nitems);
		int cnt, n, span;
		box_t anchor, b;
		cnt = 0;
		while (cnt < nitems) begin
			n = ($urandom_range(15) == 0) ? $urandom_range(NBOX + 2, NBOX) :
				$urandom_range(12, 1);
			span = ($urandom_range(3) == 0) ? 4095 : $urandom_range(400, 4);
			anchor = rand_box(span);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(1)) begin
					// cluster around an anchor so suppression happens
					b = anchor;
					b.left = b.left + CB'($urandom_range(span / 4 + 1));
					b.top = b.top + CB'($urandom_range(span / 4 + 1));
					b.score = SB'($urandom);
				end else b = rand_box(span);
				if ($urandom_range(19) == 0) b = mk(b.right, b.bottom, b.left, b.top, b.score);
				queue_box(b, i == n - 1);
			end
			cnt += n;
		end
	endtask

	initial begin
		thr = THR_RESET;
		mode = MODE_IOU;
		drop_seen = 0;
		errors = 0;
		sets_done = 0;
		kept_seen = 0;
		loads_sent = 0;
		idle_cnt = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, ties, reversed extents, disjoint, single box
		queue_box(mk(0, 0, 4095, 4095, 65535), 0);
		queue_box(mk(0, 0, 4095, 4095, 0), 0);
		queue_box(mk(10, 10, 20, 20, 500), 0);
		queue_box(mk(10, 10, 20, 20, 500), 0);
		queue_box(mk(20, 20, 10, 10, 400), 0);
		queue_box(mk(4095, 4095, 4095, 4095, 300), 0);
		queue_box(mk(100, 100, 200, 200, 300), 1);
		queue_box(mk(5, 5, 5, 5, 1), 1);
		queue_box(mk(0, 0, 9, 9, 100), 0);
		queue_box(mk(10, 0, 19, 9, 90), 0);
		queue_box(mk(2, 2, 11, 11, 80), 1);
		drain();
		write_reg(REG_MODE, REG_BITS'(MODE_IOS));
		write_reg(REG_THRESHOLD, 16'd0);
		queue_box(mk(0, 0, 99, 99, 900), 0);
		queue_box(mk(50, 50, 60, 60, 800), 0);
		queue_box(mk(99, 99, 200, 200, 700), 0);
		queue_box(mk(101, 0, 150, 50, 600), 1);
		drain();
		write_reg(REG_MODE, REG_BITS'(MODE_NONE));
		queue_box(mk(0, 0, 9, 9, 5), 0);
		queue_box(mk(0, 0, 9, 9, 5), 1);
		drain();
		write_reg(REG_MODE, 16'd3);
		write_reg(2'd2, 16'hffff);
		write_reg(2'd3, 16'h0);
		queue_box(mk(1, 1, 2, 2, 7), 0);
		queue_box(mk(1, 1, 2, 2, 8), 1);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 52; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 52; end
				default: begin send_idle_pct = 34; recv_stall_pct = 34; end
			endcase
			write_reg(REG_MODE, REG_BITS'(ph % 3 == 0 ? MODE_IOU :
				ph % 3 == 1 ? MODE_IOS : MODE_NONE));
			write_reg(REG_THRESHOLD, ph == 2 ? 16'hffff : ph == 5 ? 16'd1 :
				REG_BITS'($urandom));
			random_sets(22);
			drain();
		end

		$display("loaded %0d boxes, checked %0d kept boxes over %0d sets",
			loads_sent, kept_seen, sets_done);
		$display("covered all overlap modes, threshold extremes, store overflow and stalls");
		if (errors == 0 && kept_expected.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### sim.f
design/nms_pkg.sv
design/nms_cell.sv
design/nms_ovl.sv
design/non_maximum_suppression.sv
design/nms_check.sv
tb/non_maximum_suppression_tb.sv
